### rtl/tpc_pkg.sv
// shared types and constants for the twin prime pair checker
// no dependencies; imported by every module of the block
package tpc_pkg;

    localparam int VALUE_BITS = 16;
    // trial divisors never pass sqrt(2^VALUE_BITS) + 1
    localparam int DIV_BITS   = (VALUE_BITS + 1) / 2 + 1;
    // running square of the divisor, one past the value range
    localparam int SQ_BITS    = VALUE_BITS + 1;
    localparam int CNT_BITS   = $clog2(VALUE_BITS);
    localparam logic [CNT_BITS-1:0] LAST_BIT = CNT_BITS'(VALUE_BITS - 1);

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_status;

    typedef struct packed {
        logic done;
        logic prime;
    } t_tst_result;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_CHECK,
        TS_DIVIDE
    } t_tst_state;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIRST,
        S_SECOND
    } t_top_state;

endpackage

### rtl/tpc_rem_unit.sv
// bit-serial remainder unit: one dividend bit per cycle, msb first
// depends on tpc_pkg
module tpc_rem_unit import tpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [DIV_BITS-1:0]   i_divisor,
    output t_rem_status           o_status
);

    logic                  r_busy, n_busy;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [VALUE_BITS-1:0] r_sh, n_sh;
    logic [DIV_BITS-1:0]   r_div, n_div;
    logic [DIV_BITS-1:0]   r_rem, n_rem;
    t_rem_status           r_status, n_status;
    logic [DIV_BITS:0]     w_trial;

    always_comb begin
        w_trial  = {r_rem, r_sh[VALUE_BITS-1]};
        n_busy   = r_busy;
        n_cnt    = r_cnt;
        n_sh     = r_sh;
        n_div    = r_div;
        n_rem    = r_rem;
        n_status = '0;
        if (i_load) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_sh   = i_dividend;
            n_div  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            // restoring step
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = DIV_BITS'(w_trial - {1'b0, r_div});
            end else begin
                n_rem = DIV_BITS'(w_trial);
            end
            n_sh  = r_sh << 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST_BIT) begin
                n_busy        = 1'b0;
                n_status.done = 1'b1;
                n_status.zero = (n_rem == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_status <= '0;
        end else begin
            r_busy   <= n_busy;
            r_cnt    <= n_cnt;
            r_status <= n_status;
        end
        r_sh  <= n_sh;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_status = r_status;

endmodule

### rtl/tpc_prime_tester.sv
// trial division sequencer: steps divisors 2, 3, ... while d*d <= n
// depends on tpc_pkg and tpc_rem_unit
module tpc_prime_tester import tpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_value,
    output t_tst_result           o_result
);

    t_tst_state            r_state, n_state;
    logic [VALUE_BITS-1:0] r_n, n_n;
    logic [DIV_BITS-1:0]   r_d, n_d;
    logic [SQ_BITS-1:0]    r_sq, n_sq;
    t_tst_result           r_result, n_result;
    logic                  w_load;
    t_rem_status           w_rem;

    tpc_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_dividend (r_n),
        .i_divisor  (r_d),
        .o_status   (w_rem)
    );

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_d      = r_d;
        n_sq     = r_sq;
        n_result = '0;
        w_load   = 1'b0;
        case (r_state)
            TS_IDLE: begin
                if (i_start) begin
                    n_n  = i_value;
                    n_d  = DIV_BITS'(2);
                    n_sq = SQ_BITS'(4);
                    if (i_value < VALUE_BITS'(2)) begin
                        // zero and one are not prime
                        n_result.done = 1'b1;
                    end else begin
                        n_state = TS_CHECK;
                    end
                end
            end
            TS_CHECK: begin
                if (r_sq > {1'b0, r_n}) begin
                    n_result.done  = 1'b1;
                    n_result.prime = 1'b1;
                    n_state        = TS_IDLE;
                end else begin
                    w_load  = 1'b1;
                    n_state = TS_DIVIDE;
                end
            end
            TS_DIVIDE: begin
                if (w_rem.done) begin
                    if (w_rem.zero) begin
                        n_result.done = 1'b1;
                        n_state       = TS_IDLE;
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        n_sq    = r_sq + SQ_BITS'({r_d, 1'b1});
                        n_d     = r_d + 1'b1;
                        n_state = TS_CHECK;
                    end
                end
            end
            default: begin
                n_state = TS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= TS_IDLE;
            r_result <= '0;
        end else begin
            r_state  <= n_state;
            r_result <= n_result;
        end
        r_n  <= n_n;
        r_d  <= n_d;
        r_sq <= n_sq;
    end

    assign o_result = r_result;

endmodule

### rtl/twin_prime_pair_checker_top.sv
// top level of the twin prime pair checker
// depends on tpc_pkg and tpc_prime_tester (which holds tpc_rem_unit)

// A request (first and second value) is taken when start is high and busy
// is low. The first value is tested, then the second, on one shared trial
// division engine. For each trial divisor the sequencer checks the divisor
// bound, the bit-serial remainder unit consumes one dividend bit per cycle,
// and the remainder is handed back. A prime value tries every divisor up
// to its square root; a composite value stops at its smallest divisor.
// The result shows on the output ports for exactly one cycle with o_valid
// high; the receiver cannot stall it, so it must take it in that cycle. A
// new request may be given as soon as busy drops, which is the same cycle
// the result is shown.
module twin_prime_pair_checker_top import tpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] i_first_value,
    input  logic [VALUE_BITS-1:0] i_second_value,
    output logic                  busy,
    output logic                  o_valid,
    output logic                  o_pair_is_twin,
    output logic                  o_first_is_prime,
    output logic                  o_second_is_prime
);

    t_top_state            r_state, n_state;
    logic [VALUE_BITS-1:0] r_first, n_first;
    logic [VALUE_BITS-1:0] r_second, n_second;
    logic                  r_first_prime, n_first_prime;
    logic                  r_valid, n_valid;
    logic                  r_twin, n_twin;
    logic                  r_pa, n_pa;
    logic                  r_pb, n_pb;
    logic                  w_tst_start;
    logic [VALUE_BITS-1:0] w_tst_value;
    t_tst_result           w_tst;
    logic                  w_gap_ok;

    tpc_prime_tester u_tester (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_tst_start),
        .i_value  (w_tst_value),
        .o_result (w_tst)
    );

    // second == first + 2, sum formed one bit wider so it never wraps
    assign w_gap_ok = (({1'b0, r_first} + (VALUE_BITS + 1)'(2)) == {1'b0, r_second});

    always_comb begin
        n_state       = r_state;
        n_first       = r_first;
        n_second      = r_second;
        n_first_prime = r_first_prime;
        n_valid       = 1'b0;
        n_twin        = r_twin;
        n_pa          = r_pa;
        n_pb          = r_pb;
        w_tst_start   = 1'b0;
        w_tst_value   = r_second;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    // launch the first test straight from the ports
                    n_first     = i_first_value;
                    n_second    = i_second_value;
                    w_tst_start = 1'b1;
                    w_tst_value = i_first_value;
                    n_state     = S_FIRST;
                end
            end
            S_FIRST: begin
                if (w_tst.done) begin
                    n_first_prime = w_tst.prime;
                    w_tst_start   = 1'b1;
                    n_state       = S_SECOND;
                end
            end
            S_SECOND: begin
                if (w_tst.done) begin
                    n_valid = 1'b1;
                    n_pa    = r_first_prime;
                    n_pb    = w_tst.prime;
                    n_twin  = r_first_prime & w_tst.prime & w_gap_ok;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_first       <= n_first;
        r_second      <= n_second;
        r_first_prime <= n_first_prime;
        r_twin        <= n_twin;
        r_pa          <= n_pa;
        r_pb          <= n_pb;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_pair_is_twin    = r_twin;
    assign o_first_is_prime  = r_pa;
    assign o_second_is_prime = r_pb;

endmodule

### tb/twin_prime_pair_checker_top_test.sv
// self-checking testbench for twin_prime_pair_checker_top: directed corner pairs, then
// random twin-heavy traffic under several sender idle mixes, scored against a trial division model
// depends on tpc_pkg and the rtl of the block
module twin_prime_pair_checker_top_test;
    import tpc_pkg::*;

    localparam int unsigned MAX_VALUE      = (1 << VALUE_BITS) - 1;
    localparam int          CLK_HALF       = 5;
    localparam int          RESET_CYCLES   = 8;
    localparam int          ITEMS_PER_MIX  = 19;
    // worst request is two large primes; allow every request that long plus a long sender gap,
    // several times over
    localparam longint      TIMEOUT_CYCLES = 5_000_000;
    localparam int          SETTLE_CYCLES  = 32;
    localparam int          MAX_REPORTS    = 10;

    // keeps the verdicts owed by the block, in request order, and scores each result
    class verdict_tracker;
        typedef struct {
            logic [VALUE_BITS-1:0] first_val;
            logic [VALUE_BITS-1:0] second_val;
            bit                    twin;
            bit                    first_prime;
            bit                    second_prime;
        } t_verdict;

        t_verdict    pending_verdicts[$];
        int unsigned requests_seen;
        int unsigned results_seen;
        int unsigned twins_seen;
        int unsigned first_primes_seen;
        int unsigned mismatches;

        // trial division, stopping at the square root
        static function bit trial_div_prime(logic [VALUE_BITS-1:0] n);
            int unsigned v;
            int unsigned d;
            v = n;
            if (v < 2) return 1'b0;
            for (d = 2; d * d <= v; d++) begin
                if (v % d == 0) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_request(logic [VALUE_BITS-1:0] first_val,
                                   logic [VALUE_BITS-1:0] second_val);
            t_verdict v;
            v.first_val    = first_val;
            v.second_val   = second_val;
            v.first_prime  = trial_div_prime(first_val);
            v.second_prime = trial_div_prime(second_val);
            // the sum is one bit wider, so it never wraps onto a small second value
            v.twin = v.first_prime && v.second_prime &&
                     ({1'b0, first_val} + (VALUE_BITS + 1)'(2) == {1'b0, second_val});
            pending_verdicts.push_back(v);
            requests_seen++;
            if (v.twin) twins_seen++;
            if (v.first_prime) first_primes_seen++;
        endfunction

        function void flag(string what, t_verdict v, bit exp_bit, logic got_bit);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch: %s for (%0d, %0d) expected %0b got %0b",
                         what, v.first_val, v.second_val, exp_bit, got_bit);
        endfunction

        function void check_result(logic twin, logic first_prime, logic second_prime);
            t_verdict v;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: result with no request outstanding (%b%b%b)",
                             twin, first_prime, second_prime);
                return;
            end
            v = pending_verdicts.pop_front();
            results_seen++;
            if (twin !== v.twin) flag("pair_is_twin", v, v.twin, twin);
            if (first_prime !== v.first_prime)
                flag("first_is_prime", v, v.first_prime, first_prime);
            if (second_prime !== v.second_prime)
                flag("second_is_prime", v, v.second_prime, second_prime);
        endfunction

        function bit clean();
            return mismatches == 0 && pending_verdicts.size() == 0;
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic [VALUE_BITS-1:0] i_first_value;
    logic [VALUE_BITS-1:0] i_second_value;
    logic                  busy;
    logic                  o_valid;
    logic                  o_pair_is_twin;
    logic                  o_first_is_prime;
    logic                  o_second_is_prime;

    verdict_tracker tracker = new();

    always #CLK_HALF i_clk = ~i_clk;

    twin_prime_pair_checker_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .i_first_value    (i_first_value),
        .i_second_value   (i_second_value),
        .busy             (busy),
        .o_valid          (o_valid),
        .o_pair_is_twin   (o_pair_is_twin),
        .o_first_is_prime (o_first_is_prime),
        .o_second_is_prime(o_second_is_prime)
    );

    // results live for one cycle only, so every edge after reset is checked for o_valid; the values read
    // here are the ones that held during the cycle the edge ends
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid !== 1'b0)
            tracker.check_result(o_pair_is_twin, o_first_is_prime, o_second_is_prime);
    end

    // hard stop in case the block hangs or never drops busy
    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("timeout with %0d verdicts outstanding", tracker.pending_verdicts.size());
        $display("twin_prime_pair_checker_top_test NOT OK");
        $finish;
    end

    // holds start high with the pair until an edge sees busy low; start is left high so a
    // request can follow back to back without a second assignment in the same step
    task automatic issue_request(input logic [VALUE_BITS-1:0] first_val,
                                 input logic [VALUE_BITS-1:0] second_val);
        start          <= 1'b1;
        i_first_value  <= first_val;
        i_second_value <= second_val;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.note_request(first_val, second_val);
    endtask

    // random sender pause after a request; the lengths are spread so that the next start
    // lands early in the trial division, around the end of it, or right after busy falls
    task automatic sender_gap(input int idle_pct);
        int unsigned n;
        if ($urandom_range(99) >= idle_pct) return;
        start <= 1'b0;
        case ($urandom_range(3))
            0: n = $urandom_range(1, 1500);
            1: begin
                do @(posedge i_clk); while (busy !== 1'b0);
                n = $urandom_range(3);
            end
            default: n = $urandom_range(1, 6);
        endcase
        repeat (n) @(posedge i_clk);
    endtask

    // stop sending until every owed verdict has come back
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_verdicts.size() != 0);
    endtask

    function automatic int unsigned prime_from(int unsigned from);
        int unsigned v;
        for (v = from; v <= MAX_VALUE; v++) begin
            if (verdict_tracker::trial_div_prime(v[VALUE_BITS-1:0])) return v;
        end
        return 2;
    endfunction

    // lower member of the first twin pair at or above from
    function automatic int unsigned twin_from(int unsigned from);
        int unsigned v;
        for (v = from; v + 2 <= MAX_VALUE; v++) begin
            if (verdict_tracker::trial_div_prime(v[VALUE_BITS-1:0]) &&
                verdict_tracker::trial_div_prime(VALUE_BITS'(v + 2))) return v;
        end
        return 3;
    endfunction

    // random pair: mostly small values, since large primes take long to test; about two in five
    // are twin pairs, the rest primes at even gaps, near misses and plain noise
    task automatic pick_pair(output logic [VALUE_BITS-1:0] first_val,
                             output logic [VALUE_BITS-1:0] second_val);
        int unsigned base;
        int unsigned kind;
        int unsigned p;
        base = ($urandom_range(9) == 0) ? $urandom_range(MAX_VALUE) : $urandom_range(2047);
        kind = $urandom_range(99);
        if (kind < 40) begin
            p          = twin_from(base);
            first_val  = VALUE_BITS'(p);
            second_val = VALUE_BITS'(p + 2);
        end else if (kind < 60) begin
            // prime first, second at a gap of zero, two, four or six (wraps near the top)
            p          = prime_from(base);
            first_val  = VALUE_BITS'(p);
            second_val = VALUE_BITS'(p + 2 * $urandom_range(3));
        end else if (kind < 75) begin
            first_val  = VALUE_BITS'($urandom_range(MAX_VALUE));
            second_val = VALUE_BITS'($urandom_range(MAX_VALUE));
        end else begin
            // small values close together, either order; zero minus two wraps to the top
            first_val  = VALUE_BITS'($urandom_range(1023));
            second_val = VALUE_BITS'(first_val + $urandom_range(4) - 2);
            if ($urandom_range(1)) {first_val, second_val} = {second_val, first_val};
        end
    endtask

    initial begin
        // sender idle percent per mix; the third mix stands for receiver stalls, which this
        // interface has no way to apply, so it runs the sender flat out
        int                    sender_idle_pct[4];
        logic [VALUE_BITS-1:0] dir_first[$];
        logic [VALUE_BITS-1:0] dir_second[$];
        logic [VALUE_BITS-1:0] a;
        logic [VALUE_BITS-1:0] b;
        int unsigned           top_twin;
        int                    mix;
        int                    k;

        sender_idle_pct = '{0, 64, 0, 28};
        start          <= 1'b0;
        i_first_value  <= '0;
        i_second_value <= '0;
        i_rst_n        <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // largest twin pair in range, the slowest twin the block can see
        for (top_twin = MAX_VALUE - 2; top_twin > 3; top_twin--) begin
            if (verdict_tracker::trial_div_prime(VALUE_BITS'(top_twin)) &&
                verdict_tracker::trial_div_prime(VALUE_BITS'(top_twin + 2))) break;
        end

        // zero and one are never prime
        dir_first.push_back(0);       dir_second.push_back(0);
        dir_first.push_back(0);       dir_second.push_back(2);
        dir_first.push_back(1);       dir_second.push_back(1);
        dir_first.push_back(1);       dir_second.push_back(3);
        // two and three are prime without any divisor tried
        dir_first.push_back(2);       dir_second.push_back(3);
        dir_first.push_back(2);       dir_second.push_back(4);
        dir_first.push_back(3);       dir_second.push_back(5);
        dir_first.push_back(5);       dir_second.push_back(7);
        // right gap, wrong order; equal primes
        dir_first.push_back(5);       dir_second.push_back(3);
        dir_first.push_back(7);       dir_second.push_back(7);
        dir_first.push_back(4);       dir_second.push_back(6);
        dir_first.push_back(9);       dir_second.push_back(11);
        dir_first.push_back(11);      dir_second.push_back(13);
        dir_first.push_back(17);      dir_second.push_back(19);
        // prime squares sit right on the divisor bound
        dir_first.push_back(25);      dir_second.push_back(27);
        dir_first.push_back(289);     dir_second.push_back(291);
        dir_first.push_back(63001);   dir_second.push_back(63003);
        // top of the range: all ones, and a first value whose plus two would wrap
        dir_first.push_back(16'hffff); dir_second.push_back(16'hffff);
        dir_first.push_back(16'hffff); dir_second.push_back(1);
        dir_first.push_back(16'hfffe); dir_second.push_back(0);
        dir_first.push_back(65521);   dir_second.push_back(65521);
        dir_first.push_back(65521);   dir_second.push_back(65523);
        dir_first.push_back(VALUE_BITS'(top_twin));
        dir_second.push_back(VALUE_BITS'(top_twin + 2));
        dir_first.push_back(VALUE_BITS'(top_twin + 2));
        dir_second.push_back(VALUE_BITS'(top_twin));

        foreach (dir_first[i]) issue_request(dir_first[i], dir_second[i]);
        drain();

        for (mix = 0; mix < 4; mix++) begin
            for (k = 0; k < ITEMS_PER_MIX; k++) begin
                pick_pair(a, b);
                issue_request(a, b);
                sender_gap(sender_idle_pct[mix]);
                // one full drain in the middle of the mix with the most sender idle
                if (mix == 1 && k == ITEMS_PER_MIX / 2) drain();
            end
            drain();
        end

        // every owed result is in by now; watch a little longer for strays
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d requests scored over four idle mixes: %0d twin pairs, %0d prime first values",
                 tracker.requests_seen, tracker.twins_seen, tracker.first_primes_seen);
        $display("%0d results checked, %0d mismatches, %0d verdicts outstanding",
                 tracker.results_seen, tracker.mismatches, tracker.pending_verdicts.size());
        if (tracker.clean())
            $display("twin_prime_pair_checker_top_test OK");
        else
            $display("twin_prime_pair_checker_top_test NOT OK");
        $finish;
    end

endmodule

### sim.f
rtl/tpc_pkg.sv
rtl/tpc_rem_unit.sv
rtl/tpc_prime_tester.sv
rtl/twin_prime_pair_checker_top.sv
tb/twin_prime_pair_checker_top_test.sv
